/* hdl/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, silent during reset.
`define SLLA_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication form of the above.
`define SLLA_ASSERT_IMPL(name, ante, cons, msg) \
	`SLLA_ASSERT(name, (ante) |-> (cons), msg)

`endif

/* hdl/slla_pkg.sv */
// Types, constants and register codes of the slew-limited lag actuator.
`timescale 1ns / 1ps
package slla_pkg;

	localparam int ANGLE_W       = 16;
	localparam int THR_W         = 15;
	localparam int THROTTLE_FULL = 16384;
	localparam int TAU_W         = 16;
	localparam int STOP_W        = 15;
	localparam int DT_W          = 16;
	localparam int ERR_W         = ANGLE_W + 1;
	localparam int PROD1_W       = ERR_W + TAU_W + 1;
	localparam int RATE_FULL_W   = PROD1_W - 8;
	localparam int RATE_W        = 25;
	localparam int PROD2_W       = RATE_W + DT_W + 1;
	localparam int DELTA_W       = PROD2_W - 16;
	localparam int SUM_W         = DELTA_W + 1;
	localparam int LANES         = 6;
	localparam int LANE_LAT      = 4;
	localparam int CNT_W         = $clog2(LANE_LAT);
	localparam int ADDR_W        = 5;
	localparam int DATA_W        = 32;
	localparam int IDX_W         = ADDR_W - 2;

	localparam int LANE_ELEVATOR = 0;
	localparam int LANE_AILERON  = 1;
	localparam int LANE_RUDDER   = 2;
	localparam int LANE_PITCH    = 3;
	localparam int LANE_YAW      = 4;
	localparam int LANE_THROTTLE = 5;

	typedef enum logic [IDX_W-1:0] {
		REG_INV_SURFACE_TAU  = 3'd0,
		REG_SLEW_RATE_LIMIT  = 3'd1,
		REG_SURFACE_STOP     = 3'd2,
		REG_GIMBAL_STOP      = 3'd3,
		REG_INV_THROTTLE_TAU = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} ctl_state_t;

	typedef struct packed {
		logic [TAU_W-1:0]  inv_surface_tau;
		logic [TAU_W-1:0]  slew_rate_limit;
		logic [STOP_W-1:0] surface_stop;
		logic [STOP_W-1:0] gimbal_stop;
		logic [TAU_W-1:0]  inv_throttle_tau;
	} cfg_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] elevator_cmd;
		logic signed [ANGLE_W-1:0] aileron_cmd;
		logic signed [ANGLE_W-1:0] rudder_cmd;
		logic signed [ANGLE_W-1:0] pitch_gimbal_cmd;
		logic signed [ANGLE_W-1:0] yaw_gimbal_cmd;
		logic signed [ANGLE_W-1:0] throttle_cmd;
		logic [DT_W-1:0]           time_step;
	} cmd_item_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] elevator_pos;
		logic signed [ANGLE_W-1:0] aileron_pos;
		logic signed [ANGLE_W-1:0] rudder_pos;
		logic signed [ANGLE_W-1:0] pitch_gimbal_pos;
		logic signed [ANGLE_W-1:0] yaw_gimbal_pos;
		logic [THR_W-1:0]          throttle_pos;
	} pos_item_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] cmd;
		logic signed [ANGLE_W-1:0] pos;
		logic [TAU_W-1:0]          inv_tau;
		logic                      limited;
		logic [TAU_W-1:0]          limit;
		logic [DT_W-1:0]           dt;
		logic signed [ANGLE_W-1:0] lo;
		logic signed [ANGLE_W-1:0] hi;
	} lane_in_t;

endpackage

/* hdl/slla_ifs.sv */
// Valid/ready channel interfaces for commands and positions.
`timescale 1ns / 1ps
interface slla_cmd_if import slla_pkg::*;;
	logic      valid;
	logic      ready;
	cmd_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface slla_pos_if import slla_pkg::*;;
	logic      valid;
	logic      ready;
	pos_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hdl/slla_regs.sv */
// APB register file holding the actuator configuration.
`timescale 1ns / 1ps
module slla_regs import slla_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t             cfg_q;
	logic [IDX_W-1:0] idx;
	logic             wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inv_surface_tau  <= TAU_W'(5120);
			cfg_q.slew_rate_limit  <= TAU_W'(34310);
			cfg_q.surface_stop     <= STOP_W'(7149);
			cfg_q.gimbal_stop      <= STOP_W'(2860);
			cfg_q.inv_throttle_tau <= TAU_W'(512);
		end else if (wr_en) begin
			unique case (idx)
				REG_INV_SURFACE_TAU:  cfg_q.inv_surface_tau  <= pwdata[TAU_W-1:0];
				REG_SLEW_RATE_LIMIT:  cfg_q.slew_rate_limit  <= pwdata[TAU_W-1:0];
				REG_SURFACE_STOP:     cfg_q.surface_stop     <= pwdata[STOP_W-1:0];
				REG_GIMBAL_STOP:      cfg_q.gimbal_stop      <= pwdata[STOP_W-1:0];
				REG_INV_THROTTLE_TAU: cfg_q.inv_throttle_tau <= pwdata[TAU_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_INV_SURFACE_TAU:  prdata = DATA_W'(cfg_q.inv_surface_tau);
			REG_SLEW_RATE_LIMIT:  prdata = DATA_W'(cfg_q.slew_rate_limit);
			REG_SURFACE_STOP:     prdata = DATA_W'(cfg_q.surface_stop);
			REG_GIMBAL_STOP:      prdata = DATA_W'(cfg_q.gimbal_stop);
			REG_INV_THROTTLE_TAU: prdata = DATA_W'(cfg_q.inv_throttle_tau);
			default:              prdata = '0;
		endcase
	end

endmodule

/* hdl/slla_lane.sv */
// One lag lane: error times inverse tau, optional rate clamp, times dt, add and stop clamp.
`timescale 1ns / 1ps
module slla_lane import slla_pkg::*; (
	input  logic                      clk,
	input  lane_in_t                  lin,
	output logic signed [ANGLE_W-1:0] pos_new
);

	logic signed [ERR_W-1:0]       err;
	logic signed [PROD1_W-1:0]     prod1_s1;
	logic signed [PROD1_W-1:0]     p1_bias;
	logic signed [RATE_FULL_W-1:0] rate_full;
	logic signed [RATE_FULL_W-1:0] lim_pos;
	logic signed [RATE_FULL_W-1:0] rate_c;
	logic signed [RATE_W-1:0]      rate_s2;
	logic signed [PROD2_W-1:0]     prod2_s3;
	logic signed [PROD2_W-1:0]     p2_bias;
	logic signed [DELTA_W-1:0]     delta;
	logic signed [SUM_W-1:0]       sum;
	logic signed [SUM_W-1:0]       sum_lo;
	logic signed [SUM_W-1:0]       sum_hi;
	logic signed [SUM_W-1:0]       sum_c;
	logic signed [ANGLE_W-1:0]     pos_s4;

	// Stage 1: error times inverse time constant.
	assign err = ERR_W'(lin.cmd) - ERR_W'(lin.pos);

	always_ff @(posedge clk) begin
		prod1_s1 <= err * $signed({1'b0, lin.inv_tau});
	end

	// Stage 2: divide by 256 toward zero, then the slew clamp if the lane is limited.
	always_comb begin
		p1_bias   = prod1_s1 + (prod1_s1[PROD1_W-1] ? PROD1_W'(255) : PROD1_W'(0));
		rate_full = p1_bias[PROD1_W-1:8];
		lim_pos   = RATE_FULL_W'($signed({1'b0, lin.limit}));
		rate_c    = rate_full;
		if (lin.limited) begin
			if (rate_full > lim_pos) begin
				rate_c = lim_pos;
			end else if (rate_full < -lim_pos) begin
				rate_c = -lim_pos;
			end
		end
	end

	always_ff @(posedge clk) begin
		rate_s2 <= rate_c[RATE_W-1:0];
	end

	// Stage 3: rate times time step.
	always_ff @(posedge clk) begin
		prod2_s3 <= rate_s2 * $signed({1'b0, lin.dt});
	end

	// Stage 4: divide by 65536 toward zero, advance and clamp to the stops.
	always_comb begin
		p2_bias = prod2_s3 + (prod2_s3[PROD2_W-1] ? PROD2_W'(65535) : PROD2_W'(0));
		delta   = p2_bias[PROD2_W-1:16];
		sum     = SUM_W'(delta) + SUM_W'(lin.pos);
		sum_lo  = SUM_W'(lin.lo);
		sum_hi  = SUM_W'(lin.hi);
		sum_c   = sum;
		if (sum < sum_lo) begin
			sum_c = sum_lo;
		end else if (sum > sum_hi) begin
			sum_c = sum_hi;
		end
	end

	always_ff @(posedge clk) begin
		pos_s4 <= sum_c[ANGLE_W-1:0];
	end

	assign pos_new = pos_s4;

endmodule

/* hdl/slla_merge.sv */
// Merge stage: commits lane results to the held positions and the output register.
`timescale 1ns / 1ps
module slla_merge import slla_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      commit,
	input  logic signed [ANGLE_W-1:0] lane_pos [LANES],
	output logic signed [ANGLE_W-1:0] state_pos [LANES],
	output logic                      room,
	slla_pos_if.source                pos
);

	logic signed [ANGLE_W-1:0] state_q [LANES];
	pos_item_t                 out_q;
	logic                      out_valid_q;

	assign room      = !out_valid_q || pos.ready;
	assign state_pos = state_q;
	assign pos.valid = out_valid_q;
	assign pos.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANES; i++) begin
				state_q[i] <= '0;
			end
			out_valid_q <= 1'b0;
		end else if (commit) begin
			state_q     <= lane_pos;
			out_valid_q <= 1'b1;
		end else if (pos.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_q.elevator_pos     <= lane_pos[LANE_ELEVATOR];
			out_q.aileron_pos      <= lane_pos[LANE_AILERON];
			out_q.rudder_pos       <= lane_pos[LANE_RUDDER];
			out_q.pitch_gimbal_pos <= lane_pos[LANE_PITCH];
			out_q.yaw_gimbal_pos   <= lane_pos[LANE_YAW];
			out_q.throttle_pos     <= lane_pos[LANE_THROTTLE][THR_W-1:0];
		end
	end

endmodule

/* hdl/slew_limited_lag_actuator_top.sv */
// Top level of the slew-limited first-order lag actuator.
//
//  channel  | kind          | moves
//  ---------+---------------+------------------------------------------
//  cmd      | valid/ready   | six commands and the time step
//  pos      | valid/ready   | six new positions
//  apb      | psel/penable  | configuration registers at 4*index
//
// An item passes from the command capture through the lane pipeline (two multiplies,
// each followed by its divide and clamp) to the commit, which waits for room in the output register.
// Six lanes run side by side; the merge stage writes back the held positions.
// arst_n clears the positions to zero and loads the default registers.
// A result waiting in the output register does not block the next command;
// only the commit waits for pos to drain.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module slew_limited_lag_actuator_top import slla_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	slla_cmd_if.sink          cmd,
	slla_pos_if.source        pos,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t                      cfg;
	cmd_item_t                 cmd_q;
	ctl_state_t                state_q, state_d;
	logic [CNT_W-1:0]          cnt_q, cnt_d;
	logic                      accept;
	logic                      commit;
	logic                      room;
	logic signed [ANGLE_W-1:0] tcmd;
	logic signed [ANGLE_W-1:0] lane_pos [LANES];
	logic signed [ANGLE_W-1:0] state_pos [LANES];
	logic signed [ANGLE_W-1:0] surf_hi, gimb_hi;
	lane_in_t                  lin [LANES];

	slla_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd.data;
		end
	end

	// Throttle command saturates to 0..full before the lag.
	always_comb begin
		if (cmd_q.throttle_cmd < 0) begin
			tcmd = '0;
		end else if (cmd_q.throttle_cmd > ANGLE_W'(THROTTLE_FULL)) begin
			tcmd = ANGLE_W'(THROTTLE_FULL);
		end else begin
			tcmd = cmd_q.throttle_cmd;
		end
	end

	assign surf_hi = $signed({1'b0, cfg.surface_stop});
	assign gimb_hi = $signed({1'b0, cfg.gimbal_stop});

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			lin[i].pos     = state_pos[i];
			lin[i].inv_tau = cfg.inv_surface_tau;
			lin[i].limited = 1'b1;
			lin[i].limit   = cfg.slew_rate_limit;
			lin[i].dt      = cmd_q.time_step;
			lin[i].lo      = -surf_hi;
			lin[i].hi      = surf_hi;
			lin[i].cmd     = '0;
		end
		lin[LANE_ELEVATOR].cmd = cmd_q.elevator_cmd;
		lin[LANE_AILERON].cmd  = cmd_q.aileron_cmd;
		lin[LANE_RUDDER].cmd   = cmd_q.rudder_cmd;
		lin[LANE_PITCH].cmd    = cmd_q.pitch_gimbal_cmd;
		lin[LANE_PITCH].lo     = -gimb_hi;
		lin[LANE_PITCH].hi     = gimb_hi;
		lin[LANE_YAW].cmd      = cmd_q.yaw_gimbal_cmd;
		lin[LANE_YAW].lo       = -gimb_hi;
		lin[LANE_YAW].hi       = gimb_hi;
		lin[LANE_THROTTLE].cmd     = tcmd;
		lin[LANE_THROTTLE].inv_tau = cfg.inv_throttle_tau;
		lin[LANE_THROTTLE].limited = 1'b0;
		lin[LANE_THROTTLE].lo      = '0;
		lin[LANE_THROTTLE].hi      = ANGLE_W'(THROTTLE_FULL);
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		slla_lane u_lane (
			.clk     (clk),
			.lin     (lin[g]),
			.pos_new (lane_pos[g])
		);
	end

	slla_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.commit    (commit),
		.lane_pos  (lane_pos),
		.state_pos (state_pos),
		.room      (room),
		.pos       (pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		commit  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_RUN;
					cnt_d   = '0;
				end
			end
			ST_RUN: begin
				if (cnt_q == CNT_W'(LANE_LAT - 1)) begin
					state_d = ST_DONE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_DONE: begin
				// hold the lane results until the output register frees up
				commit = room;
				if (room) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`SLLA_ASSERT(a_commit_shows, commit |=> pos.valid, "commit did not raise pos.valid")
	`SLLA_ASSERT_IMPL(a_throttle_range, pos.valid,
		pos.data.throttle_pos <= THR_W'(THROTTLE_FULL), "throttle above full")
	`SLLA_ASSERT_IMPL(a_elevator_stop, pos.valid,
		(pos.data.elevator_pos <= surf_hi) && (pos.data.elevator_pos >= -surf_hi),
		"elevator beyond surface stop")
	`SLLA_ASSERT_IMPL(a_accept_starts, accept, ##1 (state_q == ST_RUN && cnt_q == '0),
		"accepted command did not start the lanes")

endmodule

/* tb/slla_checker.sv */
// Scoreboard that predicts actuator positions from observed commands and register writes.
`timescale 1ns / 1ps
module slla_checker import slla_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	slla_cmd_if               cmd_ch,
	slla_pos_if               pos_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic [DATA_W-1:0] prdata,
	input  logic              pready,
	output int                fail_count,
	output int                pending,
	output int                checked
);

	localparam int REPORT_CAP = 60;
	localparam cfg_t POWER_ON_REGS = '{
		inv_surface_tau:  16'd5120,
		slew_rate_limit:  16'd34310,
		surface_stop:     15'd7149,
		gimbal_stop:      15'd2860,
		inv_throttle_tau: 16'd512
	};

	cfg_t                      regs;
	// one entry per angle lane; the throttle lane is held apart
	logic signed [ANGLE_W-1:0] angle_q [LANE_THROTTLE];
	logic [THR_W-1:0]          throttle_q;
	pos_item_t                 expected_positions [$];
	pos_item_t                 want_pos;
	logic [DATA_W-1:0]         reg_image;
	int                        mismatches = 0;
	int                        compared = 0;

	assign fail_count = mismatches;
	assign checked    = compared;

	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= REPORT_CAP)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string field, input logic [ANGLE_W-1:0] got,
			input logic [ANGLE_W-1:0] want);
		if (got !== want)
			report($sformatf("%s got %0d expected %0d", field, $signed(got), $signed(want)));
	endtask

	function automatic longint bound(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Position change for one lane; divisions truncate toward zero.
	function automatic longint lag_delta(input longint err, input longint inv_tau,
			input longint rate_cap, input longint dt, input bit capped);
		longint rate;
		rate = (err * inv_tau) / 256;
		if (capped)
			rate = bound(rate, -rate_cap, rate_cap);
		return (rate * dt) / 65536;
	endfunction

	// Advance all six lanes by one step and return the new positions.
	function automatic pos_item_t advance_positions(input cmd_item_t c);
		logic signed [ANGLE_W-1:0] target [LANE_THROTTLE];
		longint                    dt;
		longint                    stop;
		longint                    thr_target;
		longint                    level;
		pos_item_t                 p;
		target[LANE_ELEVATOR] = c.elevator_cmd;
		target[LANE_AILERON]  = c.aileron_cmd;
		target[LANE_RUDDER]   = c.rudder_cmd;
		target[LANE_PITCH]    = c.pitch_gimbal_cmd;
		target[LANE_YAW]      = c.yaw_gimbal_cmd;
		dt = c.time_step;
		for (int i = 0; i < LANE_THROTTLE; i++) begin
			stop = (i < LANE_PITCH) ? regs.surface_stop : regs.gimbal_stop;
			angle_q[i] = ANGLE_W'(bound(longint'(angle_q[i]) +
				lag_delta(longint'(target[i]) - longint'(angle_q[i]), regs.inv_surface_tau,
				regs.slew_rate_limit, dt, 1'b1), -stop, stop));
		end
		thr_target = bound(longint'($signed(c.throttle_cmd)), 0, THROTTLE_FULL);
		level = throttle_q;
		throttle_q = THR_W'(bound(level + lag_delta(thr_target - level, regs.inv_throttle_tau,
			0, dt, 1'b0), 0, THROTTLE_FULL));
		p.elevator_pos     = angle_q[LANE_ELEVATOR];
		p.aileron_pos      = angle_q[LANE_AILERON];
		p.rudder_pos       = angle_q[LANE_RUDDER];
		p.pitch_gimbal_pos = angle_q[LANE_PITCH];
		p.yaw_gimbal_pos   = angle_q[LANE_YAW];
		p.throttle_pos     = throttle_q;
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = POWER_ON_REGS;
			foreach (angle_q[i])
				angle_q[i] = '0;
			throttle_q = '0;
			expected_positions.delete();
			pending <= 0;
		end else begin
			// retire results before taking new commands
			if (pos_ch.valid && pos_ch.ready) begin
				if (expected_positions.size() == 0) begin
					report("position transaction with no command outstanding");
				end else begin
					want_pos = expected_positions.pop_front();
					compared++;
					check_field("elevator_pos", pos_ch.data.elevator_pos, want_pos.elevator_pos);
					check_field("aileron_pos", pos_ch.data.aileron_pos, want_pos.aileron_pos);
					check_field("rudder_pos", pos_ch.data.rudder_pos, want_pos.rudder_pos);
					check_field("pitch_gimbal_pos", pos_ch.data.pitch_gimbal_pos,
						want_pos.pitch_gimbal_pos);
					check_field("yaw_gimbal_pos", pos_ch.data.yaw_gimbal_pos,
						want_pos.yaw_gimbal_pos);
					check_field("throttle_pos", ANGLE_W'(pos_ch.data.throttle_pos),
						ANGLE_W'(want_pos.throttle_pos));
				end
			end
			if (cmd_ch.valid && cmd_ch.ready)
				expected_positions.push_back(advance_positions(cmd_ch.data));
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (reg_idx_t'(paddr[ADDR_W-1:2]))
						REG_INV_SURFACE_TAU:  regs.inv_surface_tau  = pwdata[TAU_W-1:0];
						REG_SLEW_RATE_LIMIT:  regs.slew_rate_limit  = pwdata[TAU_W-1:0];
						REG_SURFACE_STOP:     regs.surface_stop     = pwdata[STOP_W-1:0];
						REG_GIMBAL_STOP:      regs.gimbal_stop      = pwdata[STOP_W-1:0];
						REG_INV_THROTTLE_TAU: regs.inv_throttle_tau = pwdata[TAU_W-1:0];
						default: ;
					endcase
				end else begin
					case (reg_idx_t'(paddr[ADDR_W-1:2]))
						REG_INV_SURFACE_TAU:  reg_image = DATA_W'(regs.inv_surface_tau);
						REG_SLEW_RATE_LIMIT:  reg_image = DATA_W'(regs.slew_rate_limit);
						REG_SURFACE_STOP:     reg_image = DATA_W'(regs.surface_stop);
						REG_GIMBAL_STOP:      reg_image = DATA_W'(regs.gimbal_stop);
						REG_INV_THROTTLE_TAU: reg_image = DATA_W'(regs.inv_throttle_tau);
						// unmapped address: nothing to compare
						default:              reg_image = prdata;
					endcase
					if (prdata !== reg_image)
						report($sformatf("register read at 0x%0h got 0x%0h expected 0x%0h",
							paddr, prdata, reg_image));
				end
			end
			pending <= expected_positions.size();
		end
	end

endmodule

/* tb/tb_top.sv */
// Testbench top: clock, reset, register programming and command stimulus for the actuator.
`timescale 1ns / 1ps
module tb_top;
	import slla_pkg::*;

	localparam int CLK_PERIOD   = 12;
	localparam int RESET_CYCLES = 2;
	localparam int ITEM_LATENCY = LANE_LAT + 2;
	localparam int NUM_REGS     = REG_INV_THROTTLE_TAU + 1;
	localparam int NUM_PHASES   = 4;
	localparam int PHASE_ITEMS  = 150;
	localparam int PAUSE_EVERY  = 50;
	localparam int TIMEOUT_NS   = 10_000_000;
	localparam int CMD_W        = $bits(cmd_item_t);

	localparam logic [ANGLE_W-1:0] ANGLE_MAX = 16'h7FFF;
	localparam logic [ANGLE_W-1:0] ANGLE_MIN = 16'h8000;
	localparam logic [ANGLE_W-1:0] THR_FULL  = ANGLE_W'(THROTTLE_FULL);
	localparam logic [DT_W-1:0]    DT_MAX    = '1;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int                fail_count;
	int                pending;
	int                checked;
	int                send_idle_pct = 0;
	int                stall_pct = 0;
	int                items_sent = 0;
	int                reg_writes = 0;
	logic [DATA_W-1:0] reg_plan [NUM_REGS];

	slla_cmd_if cmd_ch ();
	slla_pos_if pos_ch ();

	slew_limited_lag_actuator_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.pos     (pos_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	slla_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_ch     (cmd_ch),
		.pos_ch     (pos_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	always begin
		clk = 1'b0;
		#(CLK_PERIOD / 2);
		clk = 1'b1;
		#(CLK_PERIOD / 2);
	end

	always @(posedge clk) begin
		pos_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Leave valid high after a transaction; the next command or a gap decides.
	task automatic send_command(input cmd_item_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data  <= item;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic await_all_positions();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [IDX_W-1:0] idx,
			input logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (wr)
			reg_writes++;
	endtask

	// Write the plan, optionally poke unmapped addresses, then read back.
	task automatic program_regs(input bit poke_unmapped);
		for (int r = 0; r < NUM_REGS; r++)
			apb_access(1'b1, IDX_W'(r), reg_plan[r]);
		if (poke_unmapped) begin
			for (int r = NUM_REGS; r < 2 ** IDX_W; r++)
				apb_access(1'b1, IDX_W'(r), $urandom());
		end
		for (int r = 0; r < NUM_REGS; r++)
			apb_access(1'b0, IDX_W'(r), '0);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic cmd_item_t uniform_cmd(input logic [ANGLE_W-1:0] angle,
			input logic [ANGLE_W-1:0] thr, input logic [DT_W-1:0] dt);
		return '{angle, angle, angle, angle, angle, thr, dt};
	endfunction

	function automatic logic [ANGLE_W-1:0] spread(input int half);
		return ANGLE_W'(int'($urandom_range(0, 2 * half)) - half);
	endfunction

	initial begin
		#(TIMEOUT_NS);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		cmd_item_t stripes;
		cmd_item_t item;
		int        phase_end;
		int        next_pause;

		arst_n       <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.data  <= '0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// power-on registers: extremes, zero step, throttle out of range
		stripes = {16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555};
		send_command(uniform_cmd('0, '0, '0));
		send_command(uniform_cmd(ANGLE_MAX, ANGLE_MAX, DT_MAX));
		send_command(uniform_cmd(ANGLE_MAX, THR_FULL, DT_MAX));
		send_command(uniform_cmd(ANGLE_MIN, ANGLE_MIN, DT_MAX));
		send_command(uniform_cmd(ANGLE_MIN, '0, '0));
		send_command(stripes);
		send_command(uniform_cmd('0, THR_FULL, DT_W'(1)));
		send_command(~stripes);

		// all ones: top values, masked high bits, unmapped writes ignored
		await_all_positions();
		foreach (reg_plan[r])
			reg_plan[r] = '1;
		program_regs(1'b1);
		send_command(uniform_cmd(ANGLE_MAX, THR_FULL, DT_MAX));
		send_command(uniform_cmd(ANGLE_MIN, ANGLE_MIN, DT_MAX));
		send_command(uniform_cmd('0, 16'hC000, DT_W'(256)));
		send_command(stripes);

		// zero taus, zero slew, zero stops; only masked-off bits set
		await_all_positions();
		reg_plan[REG_INV_SURFACE_TAU]  = 32'hFFFF_0000;
		reg_plan[REG_SLEW_RATE_LIMIT]  = 32'hFFFF_0000;
		reg_plan[REG_SURFACE_STOP]     = 32'hFFFF_8000;
		reg_plan[REG_GIMBAL_STOP]      = 32'hFFFF_8000;
		reg_plan[REG_INV_THROTTLE_TAU] = 32'hFFFF_0000;
		program_regs(1'b0);
		send_command(uniform_cmd(ANGLE_MAX, THR_FULL, '0));
		send_command(uniform_cmd(ANGLE_MIN, '0, DT_MAX));
		send_command(uniform_cmd(ANGLE_MAX, THR_FULL, DT_MAX));

		// smallest nonzero taus and slew, widest stops
		await_all_positions();
		reg_plan[REG_INV_SURFACE_TAU]  = 32'd1;
		reg_plan[REG_SLEW_RATE_LIMIT]  = 32'd1;
		reg_plan[REG_SURFACE_STOP]     = 32'h7FFF;
		reg_plan[REG_GIMBAL_STOP]      = 32'h7FFF;
		reg_plan[REG_INV_THROTTLE_TAU] = 32'd1;
		program_regs(1'b0);
		send_command(uniform_cmd(ANGLE_MAX, THR_FULL, DT_MAX));
		send_command(uniform_cmd(ANGLE_MIN, '0, DT_MAX));

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			await_all_positions();
			send_idle_pct = (ph == 1) ? 76 : ((ph == 3) ? 37 : 0);
			stall_pct     = (ph == 2) ? 76 : ((ph == 3) ? 37 : 0);
			if (ph == 0) begin
				// power-on values
				reg_plan[REG_INV_SURFACE_TAU]  = 32'd5120;
				reg_plan[REG_SLEW_RATE_LIMIT]  = 32'd34310;
				reg_plan[REG_SURFACE_STOP]     = 32'd7149;
				reg_plan[REG_GIMBAL_STOP]      = 32'd2860;
				reg_plan[REG_INV_THROTTLE_TAU] = 32'd512;
			end else begin
				foreach (reg_plan[r])
					reg_plan[r] = (ph == 2) ? $urandom() : $urandom_range(0, 65535);
			end
			program_regs(ph == 2);
			phase_end  = items_sent + PHASE_ITEMS;
			next_pause = items_sent + PAUSE_EVERY;
			while (items_sent < phase_end) begin
				if ($urandom_range(99) < 75) begin
					// hold one target for a burst so the lag can settle toward it
					item.elevator_cmd     = spread(9000);
					item.aileron_cmd      = spread(9000);
					item.rudder_cmd       = spread(9000);
					item.pitch_gimbal_cmd = spread(3500);
					item.yaw_gimbal_cmd   = spread(3500);
					item.throttle_cmd     = ANGLE_W'($urandom_range(0, THROTTLE_FULL));
					repeat ($urandom_range(1, 8)) begin
						item.time_step = ($urandom_range(9) == 0) ? DT_W'($urandom()) :
							DT_W'($urandom_range(0, 4095));
						send_command(item);
					end
				end else begin
					item = CMD_W'({$urandom(), $urandom(), $urandom(), $urandom()});
					send_command(item);
				end
				if (items_sent >= next_pause) begin
					await_all_positions();
					next_pause += PAUSE_EVERY;
				end
			end
		end

		await_all_positions();
		repeat (4 * ITEM_LATENCY) @(posedge clk);
		$display("summary: %0d command steps over directed register extremes and %0d handshake",
			items_sent, NUM_PHASES);
		$display("summary: phases, %0d position sets compared, %0d register writes",
			checked, reg_writes);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+hdl
hdl/slla_pkg.sv
hdl/slla_ifs.sv
hdl/slla_regs.sv
hdl/slla_lane.sv
hdl/slla_merge.sv
hdl/slew_limited_lag_actuator_top.sv
tb/slla_checker.sv
tb/tb_top.sv
